@@ src/biquad_lowpass_filter_assert.svh @@
// Assertion macros for the biquad low-pass filter.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// With SYNTH defined the macros expand to nothing.
`ifndef BIQUAD_LOWPASS_FILTER_ASSERT_SVH
`define BIQUAD_LOWPASS_FILTER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: prop must hold at every sampled edge
`define BQLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("biquad_lowpass_filter: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define BQLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("biquad_lowpass_filter: assertion failed");

`else

`define BQLP_ASSERT(lbl, prop)
`define BQLP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/bqlp_pkg.sv @@
// Shared types and constants for the biquad low-pass filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bqlp_pkg;

  // Field widths and fixed-point formats
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 14;
  localparam int DELAY_W    = 32;
  localparam int DELAY_FRAC = 16;
  localparam int SCALE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier and accumulator widths
  localparam int MUL_A_W = DELAY_W + 1;
  localparam int PROD_W  = MUL_A_W + COEF_W;
  localparam int ACC_W   = PROD_W + 2;

  // Feedback rounding: drop COEF_FRAC bits, round half up
  localparam int FB_W  = ACC_W - COEF_FRAC;
  localparam int W0_W  = FB_W + 1;
  localparam logic [ACC_W-1:0] FB_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  // Output rounding: drop coefficient and delay fraction bits
  localparam int Y_SHIFT = COEF_FRAC + DELAY_FRAC;
  localparam int Y_W     = ACC_W - Y_SHIFT;
  localparam logic [ACC_W-1:0] Y_HALF = ACC_W'(1) << (Y_SHIFT - 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 3'd0,
    REG_B0     = 3'd1,
    REG_B1     = 3'd2,
    REG_B2     = 3'd3,
    REG_A1     = 3'd4,
    REG_A2     = 3'd5,
    REG_SCALE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic                     enable;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [SCALE_W-1:0]       scale;
  } cfg_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_PRE,
    MUL_A1,
    MUL_A2,
    MUL_B0,
    MUL_B1,
    MUL_B2
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // Controller sequence
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_MUL,
    ST_PRE_SAT,
    ST_FB_MUL1,
    ST_FB_MUL2,
    ST_FB_ACC,
    ST_W0,
    ST_FF_MUL0,
    ST_FF_MUL1,
    ST_FF_MUL2,
    ST_FF_ACC,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic     load_sample;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     preload;
    logic     w0_load;
    logic     out_load;
    logic     out_filtered;
    logic     shift;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/biquad_lowpass_filter.sv @@
// Channel   | handshake             | payload
// ----------+-----------------------+-----------------------------
// input     | in_valid_i/in_stall_o | op_i, sample_in_i
// output    | out_valid_o/out_stall_i | filtered_out_o
// config    | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item at a time through a single shared multiplier and accumulator.
// Filtered item: result register loaded after five multiplies (six with
// preload) through the product and accumulator registers; bypass item: loaded
// with no multiply, one with preload. The next item is accepted only once the
// sequencer has returned to idle after loading the result.
// Reset clears the delays, the sequencer and the output valid; coefficients
// reset to 0 and preload_scale to 1.0. A finished result waits in the output
// register; the next item is accepted while it waits. A stalled output register
// holds the sequencer in its last step until the waiting result leaves.
// Top level of the biquad low-pass filter. Depends on bqlp_pkg, bqlp_regs,
// bqlp_ctrl, bqlp_datapath and biquad_lowpass_filter_assert.svh.
`timescale 1ns / 1ps
`include "biquad_lowpass_filter_assert.svh"

module biquad_lowpass_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   op_i,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0]   filtered_out_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bqlp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import bqlp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  bqlp_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bqlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .enable_i   (cfg.enable),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bqlp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_out_o (filtered_out_o)
  );

  // An accepted item keeps the sequencer busy in the cycle after acceptance
  `BQLP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A blocked output register keeps the sequencer from finishing
  `BQLP_ASSERT_NEXT(a_hold_when_blocked, out_valid_o && out_stall_i && in_stall_o, in_stall_o)

  // A result only appears from the busy sequencer
  `BQLP_ASSERT(a_result_from_busy, $rose(out_valid_o) |-> $past(in_stall_o))

  // The delay line only shifts together with the load of a filtered result
  `BQLP_ASSERT(a_no_shift_in_bypass, cmd.shift |-> (cfg.enable && cmd.out_load))

endmodule

@@ src/bqlp_regs.sv @@
// Configuration register file of the biquad low-pass filter.
// Depends on bqlp_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module bqlp_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bqlp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bqlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bqlp_pkg::cfg_t            cfg_o
);
  import bqlp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always accepted
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ENABLE: cfg_d.enable = cfg_data_i[0];
        REG_B0:     cfg_d.b0     = cfg_data_i[COEF_W-1:0];
        REG_B1:     cfg_d.b1     = cfg_data_i[COEF_W-1:0];
        REG_B2:     cfg_d.b2     = cfg_data_i[COEF_W-1:0];
        REG_A1:     cfg_d.a1     = cfg_data_i[COEF_W-1:0];
        REG_A2:     cfg_d.a2     = cfg_data_i[COEF_W-1:0];
        REG_SCALE:  cfg_d.scale  = cfg_data_i[SCALE_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b0, b0: '0, b1: '0, b2: '0, a1: '0, a2: '0,
                 scale: SCALE_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/bqlp_ctrl.sv @@
// Sequencer for the biquad low-pass filter: steps the shared MAC datapath.
// Depends on bqlp_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module bqlp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic              enable_i,
  input  bqlp_pkg::status_t status_i,
  output bqlp_pkg::cmd_t    cmd_o
);
  import bqlp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_PRE;
    cmd_o.acc_op  = ACC_HOLD;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          if (op_i) begin
            state_d = ST_PRE_MUL;
          end else if (enable_i) begin
            state_d = ST_FB_MUL1;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      // sample * preload_scale
      ST_PRE_MUL: begin
        cmd_o.mul_sel = MUL_PRE;
        state_d = ST_PRE_SAT;
      end
      ST_PRE_SAT: begin
        cmd_o.preload = 1'b1;
        state_d = enable_i ? ST_FB_MUL1 : ST_RESULT;
      end
      // feedback: a1*d1 + a2*d2
      ST_FB_MUL1: begin
        cmd_o.mul_sel = MUL_A1;
        state_d = ST_FB_MUL2;
      end
      ST_FB_MUL2: begin
        cmd_o.mul_sel = MUL_A2;
        cmd_o.acc_op  = ACC_LOAD;
        state_d = ST_FB_ACC;
      end
      ST_FB_ACC: begin
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_W0;
      end
      ST_W0: begin
        cmd_o.w0_load = 1'b1;
        state_d = ST_FF_MUL0;
      end
      // feed-forward: b0*w0 + b1*d1 + b2*d2
      ST_FF_MUL0: begin
        cmd_o.mul_sel = MUL_B0;
        state_d = ST_FF_MUL1;
      end
      ST_FF_MUL1: begin
        cmd_o.mul_sel = MUL_B1;
        cmd_o.acc_op  = ACC_LOAD;
        state_d = ST_FF_MUL2;
      end
      ST_FF_MUL2: begin
        cmd_o.mul_sel = MUL_B2;
        cmd_o.acc_op  = ACC_ADD;
        state_d = ST_FF_ACC;
      end
      ST_FF_ACC: begin
        cmd_o.acc_op = ACC_ADD;
        state_d = ST_RESULT;
      end
      // wait for room in the output register
      ST_RESULT: begin
        cmd_o.out_filtered = enable_i;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.shift    = enable_i;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/bqlp_datapath.sv @@
// Datapath of the biquad low-pass filter: one shared multiplier, accumulator,
// delay registers and the output register. Depends on bqlp_pkg.
`timescale 1ns / 1ps

module bqlp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqlp_pkg::cfg_t                      cfg_i,
  input  bqlp_pkg::cmd_t                      cmd_i,
  output bqlp_pkg::status_t                   status_o,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0] filtered_out_o
);
  import bqlp_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [DELAY_W-1:0]  d1_q, d2_q, w0_q;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic [ACC_W-1:0]           acc_q, prod_ext;
  logic [ACC_W-1:0]           acc_fb_rnd, acc_y_rnd;
  logic [FB_W-1:0]            fb;
  logic [DELAY_W-1:0]         sx;
  logic [W0_W-1:0]            w0_full;
  logic                       w0_ok;
  logic [DELAY_W-1:0]         w0_d;
  logic [DELAY_W-1:0]         pre_sat;
  logic [Y_W-1:0]             y_full;
  logic [SAMPLE_W-1:0]        y_sat;
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_q;

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PRE: begin
        mul_a = {1'b0, cfg_i.scale};
        mul_b = {{(COEF_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
      end
      MUL_A1: begin
        mul_a = {d1_q[DELAY_W-1], d1_q};
        mul_b = cfg_i.a1;
      end
      MUL_A2: begin
        mul_a = {d2_q[DELAY_W-1], d2_q};
        mul_b = cfg_i.a2;
      end
      MUL_B0: begin
        mul_a = {w0_q[DELAY_W-1], w0_q};
        mul_b = cfg_i.b0;
      end
      MUL_B1: begin
        mul_a = {d1_q[DELAY_W-1], d1_q};
        mul_b = cfg_i.b1;
      end
      MUL_B2: begin
        mul_a = {d2_q[DELAY_W-1], d2_q};
        mul_b = cfg_i.b2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Product register and accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= prod_ext;
      ACC_ADD:  acc_q <= acc_q + prod_ext;
      default:  acc_q <= acc_q;
    endcase
  end

  // Preload value, saturated to the delay width
  always_comb begin
    if ((&prod_q[PROD_W-1:DELAY_W-1]) || !(|prod_q[PROD_W-1:DELAY_W-1])) begin
      pre_sat = prod_q[DELAY_W-1:0];
    end else begin
      pre_sat = {prod_q[PROD_W-1], {(DELAY_W-1){~prod_q[PROD_W-1]}}};
    end
  end

  // New delay value: sample minus rounded feedback, sample on overflow
  assign sx         = {sample_q, {DELAY_FRAC{1'b0}}};
  assign acc_fb_rnd = acc_q + FB_HALF;
  assign fb         = acc_fb_rnd[ACC_W-1:COEF_FRAC];
  assign w0_full    = {{(W0_W-DELAY_W){sx[DELAY_W-1]}}, sx} - {fb[FB_W-1], fb};
  assign w0_ok      = (&w0_full[W0_W-1:DELAY_W-1]) || !(|w0_full[W0_W-1:DELAY_W-1]);
  assign w0_d       = w0_ok ? w0_full[DELAY_W-1:0] : sx;

  // Output: round away the fraction bits, then saturate
  assign acc_y_rnd = acc_q + Y_HALF;
  assign y_full    = acc_y_rnd[ACC_W-1:Y_SHIFT];
  always_comb begin
    if ((&y_full[Y_W-1:SAMPLE_W-1]) || !(|y_full[Y_W-1:SAMPLE_W-1])) begin
      y_sat = y_full[SAMPLE_W-1:0];
    end else begin
      y_sat = {y_full[Y_W-1], {(SAMPLE_W-1){~y_full[Y_W-1]}}};
    end
  end

  // Sample and w0 holding registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.w0_load) begin
      w0_q <= w0_d;
    end
  end

  // Delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.preload) begin
      d1_q <= pre_sat;
      d2_q <= pre_sat;
    end else if (cmd_i.shift) begin
      d2_q <= d1_q;
      d1_q <= w0_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_filtered ? y_sat : sample_q;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign filtered_out_o    = out_q;

endmodule
